@@ sv/umds_pkg.sv @@
package umds_pkg;

  // Default operand width; the port fields are always 64 bits wide.
  localparam int unsigned Width = 64;

  typedef struct packed {
    logic [63:0] multiplicand;
    logic [63:0] multiplier;
    logic [63:0] divisor;
  } in_t;

  typedef struct packed {
    logic [63:0] quotient;
    logic        overflow;
  } out_t;

endpackage

@@ sv/umds_mul.sv @@
module umds_mul #(
  parameter int unsigned WIDTH = umds_pkg::Width
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [WIDTH-1:0]     a_i,
  input  logic [WIDTH-1:0]     b_i,
  output logic [2*WIDTH-1:0]   p_o
);

  // Lower half is H bits, upper half L bits, so each partial product stays
  // at or below H by H bits (32 by 32 at the default width).
  localparam int unsigned H = (WIDTH + 1) / 2;
  localparam int unsigned L = WIDTH - H;

  logic [H-1:0]     al, bl;
  logic [L-1:0]     ah, bh;
  logic [2*H-1:0]   ll_d, ll_q, ll2_q;
  logic [H+L-1:0]   lh_d, lh_q;
  logic [H+L-1:0]   hl_d, hl_q;
  logic [2*L-1:0]   hh_d, hh_q, hh2_q;
  logic [H+L:0]     mid_d, mid_q;
  logic [2*WIDTH-1:0] p_d, p_q;

  assign al = a_i[H-1:0];
  assign ah = a_i[WIDTH-1:H];
  assign bl = b_i[H-1:0];
  assign bh = b_i[WIDTH-1:H];

  assign ll_d = al * bl;
  assign lh_d = al * bh;
  assign hl_d = ah * bl;
  assign hh_d = ah * bh;

  assign mid_d = {1'b0, lh_q} + {1'b0, hl_q};

  assign p_d = {hh2_q, ll2_q} + ((2 * WIDTH)'(mid_q) << H);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q  <= ll_d;
      lh_q  <= lh_d;
      hl_q  <= hl_d;
      hh_q  <= hh_d;
      ll2_q <= ll_q;
      hh2_q <= hh_q;
      mid_q <= mid_d;
      p_q   <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

@@ sv/umds_div_cell.sv @@
module umds_div_cell #(
  parameter int unsigned WIDTH = umds_pkg::Width
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [WIDTH-1:0] rem_i,
  input  logic [WIDTH-1:0] lq_i,
  input  logic [WIDTH-1:0] d_i,
  input  logic             ovf_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rem_o,
  output logic [WIDTH-1:0] lq_o,
  output logic [WIDTH-1:0] d_o,
  output logic             ovf_o
);

  // lq holds the not yet consumed product bits at the top and the quotient
  // bits found so far at the bottom.
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             ge;
  logic             valid_q;
  logic [WIDTH-1:0] rem_d, rem_q, lq_d, lq_q, d_q;
  logic             ovf_q;

  assign trial = {rem_i, lq_i[WIDTH-1]};
  assign ge    = trial >= {1'b0, d_i};
  assign diff  = trial - {1'b0, d_i};
  assign rem_d = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
  assign lq_d  = {lq_i[WIDTH-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      lq_q  <= lq_d;
      d_q   <= d_i;
      ovf_q <= ovf_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign lq_o    = lq_q;
  assign d_o     = d_q;
  assign ovf_o   = ovf_q;

endmodule

@@ sv/unsigned_mul_div_scale_64.sv @@
// Returns floor(multiplicand * multiplier / divisor) on WIDTH-bit unsigned
// operands; input bits above WIDTH are ignored. When the high half of the
// product is at least the divisor (a zero divisor included) the quotient
// reads 0 and overflow is set. The block takes one item every cycle while
// the output is not stalled. Each item is registered in the split
// multiplier, in the overflow check, and then in each cell of a row of WIDTH
// restoring-division cells, one cell per quotient bit. A stall on the output
// holds the whole pipeline, so the input stalls in the same cycle.
module unsigned_mul_div_scale_64 #(
  parameter int unsigned WIDTH = umds_pkg::Width
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  umds_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output umds_pkg::out_t out_data_o
);

  localparam int unsigned MulLat = 3;

  logic               en;
  logic [2*WIDTH-1:0] prod;
  logic [MulLat-1:0]  mv_q;
  logic [WIDTH-1:0]   md_q [MulLat];
  logic [WIDTH-1:0]   top;

  logic               cv   [WIDTH+1];
  logic [WIDTH-1:0]   crem [WIDTH+1];
  logic [WIDTH-1:0]   clq  [WIDTH+1];
  logic [WIDTH-1:0]   cd   [WIDTH+1];
  logic               covf [WIDTH+1];

  logic               chk_v_q;
  logic [WIDTH-1:0]   chk_rem_q, chk_lq_q, chk_d_q;
  logic               chk_ovf_q;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  umds_mul #(
    .WIDTH(WIDTH)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (in_data_i.multiplicand[WIDTH-1:0]),
    .b_i   (in_data_i.multiplier[WIDTH-1:0]),
    .p_o   (prod)
  );

  // Valid and divisor travel beside the multiplier stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q    <= '0;
      chk_v_q <= 1'b0;
    end else if (en) begin
      mv_q    <= {mv_q[MulLat-2:0], in_valid_i};
      chk_v_q <= mv_q[MulLat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      md_q[0] <= in_data_i.divisor[WIDTH-1:0];
      for (int i = 1; i < MulLat; i++) begin
        md_q[i] <= md_q[i-1];
      end
    end
  end

  assign top = prod[2*WIDTH-1:WIDTH];

  always_ff @(posedge clk_i) begin
    if (en) begin
      chk_rem_q <= top;
      chk_lq_q  <= prod[WIDTH-1:0];
      chk_d_q   <= md_q[MulLat-1];
      chk_ovf_q <= top >= md_q[MulLat-1];
    end
  end

  assign cv[0]   = chk_v_q;
  assign crem[0] = chk_rem_q;
  assign clq[0]  = chk_lq_q;
  assign cd[0]   = chk_d_q;
  assign covf[0] = chk_ovf_q;

  for (genvar g = 0; g < WIDTH; g++) begin : g_cell
    umds_div_cell #(
      .WIDTH(WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cv[g]),
      .rem_i   (crem[g]),
      .lq_i    (clq[g]),
      .d_i     (cd[g]),
      .ovf_i   (covf[g]),
      .valid_o (cv[g+1]),
      .rem_o   (crem[g+1]),
      .lq_o    (clq[g+1]),
      .d_o     (cd[g+1]),
      .ovf_o   (covf[g+1])
    );
  end

  // The last cell's registers serve as the output register; the remainder
  // and divisor leaving it are not needed.
  assign out_valid_o           = cv[WIDTH];
  assign out_data_o.quotient   = covf[WIDTH] ? 64'd0 : 64'(clq[WIDTH]);
  assign out_data_o.overflow   = covf[WIDTH];

endmodule
